>>> rtl/core/mecanum_drive_mixer_core_macros.svh
// Assertion macros for the checker file of the drive mixer.
`ifndef MECANUM_DRIVE_MIXER_CORE_MACROS_SVH
`define MECANUM_DRIVE_MIXER_CORE_MACROS_SVH

// A property checked on every rising edge of clk, switched off while in reset.
`define MDM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A plain condition that must hold on every rising edge out of reset.
`define MDM_ASSERT_ALWAYS(lbl, expr, msg) \
	`MDM_ASSERT(lbl, (expr), msg)

`endif

>>> rtl/core/mdm_pkg.sv
package mdm_pkg;

	// Field and register widths.
	localparam int PULSE_W   = 12;
	localparam int CMD_W     = 11;
	localparam int SUM_W     = 12;
	localparam int CFG_IDX_W = 3;
	localparam int N_MOTORS  = 4;
	localparam int N_REGS    = 8;

	// Pulse and command ranges.
	localparam int IN_LO       = 600;
	localparam int IN_HI       = 1600;
	localparam int CMD_MAX     = 900;
	localparam int NEUTRAL     = 1500;
	localparam int END_A_RESET = 1000;
	localparam int END_B_RESET = 2000;

	// Input map: (pulse - 600) * 9 / 5, the divide done by a reciprocal.
	localparam int MAP_D_W   = 10;
	localparam int MAP_N_W   = 14;
	localparam int MAP_P_W   = 27;
	localparam int RECIP5    = 13108;
	localparam int RECIP5_SH = 16;

	// Output map: u * span / 1800, done as (p >> 3) / 225 by reciprocal.
	localparam int U_W        = 11;
	localparam int PROD_W     = 23;
	localparam int PRE_SH     = 3;
	localparam int QH_W       = 10;
	localparam int RECIP_W    = 21;
	localparam int PART_W     = QH_W + RECIP_W;
	localparam int QSUM_W     = PART_W + QH_W;
	localparam int RECIP225   = 1193047;
	localparam int RECIP225_SH = 28;

	// Edges from the accepting edge to the edge that takes the result.
	localparam int RESULT_LATENCY = 7;

	// Motor order, shared by the register map and the result ports.
	localparam int MOTOR_FL = 0;
	localparam int MOTOR_FR = 1;
	localparam int MOTOR_RR = 2;
	localparam int MOTOR_RL = 3;

	typedef logic signed [CMD_W-1:0] cmd_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [PULSE_W-1:0]      pulse_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FL_A, REG_FL_B,
		REG_FR_A, REG_FR_B,
		REG_RR_A, REG_RR_B,
		REG_RL_A, REG_RL_B
	} cfg_reg_t;

	// Saturate a widened sum back to the command range.
	function automatic cmd_t sat_cmd(input sum_t v);
		cmd_t r;
		if (v > sum_t'(CMD_MAX)) begin
			r = cmd_t'(CMD_MAX);
		end else if (v < sum_t'(-CMD_MAX)) begin
			r = cmd_t'(-CMD_MAX);
		end else begin
			r = cmd_t'(v);
		end
		return r;
	endfunction

	// Map a radio pulse onto the command range, truncating toward zero.
	// Below the low end the result always saturates, so only the
	// non-negative offsets need the exact divide.
	function automatic cmd_t pulse_to_cmd(input pulse_t p);
		logic [MAP_D_W-1:0] d;
		logic [MAP_N_W-1:0] n;
		logic [MAP_P_W-1:0] prod;
		sum_t               q;
		cmd_t               r;
		d    = MAP_D_W'(p - pulse_t'(IN_LO));
		n    = MAP_N_W'(d) * MAP_N_W'(9);
		prod = MAP_P_W'(n) * MAP_P_W'(RECIP5);
		q    = sum_t'({1'b0, prod[MAP_P_W-1:RECIP5_SH]});
		if (p < pulse_t'(IN_LO)) begin
			r = cmd_t'(-CMD_MAX);
		end else if (p >= pulse_t'(IN_HI)) begin
			r = cmd_t'(CMD_MAX);
		end else begin
			r = cmd_t'(q - sum_t'(CMD_MAX));
		end
		return r;
	endfunction

endpackage

>>> rtl/core/mecanum_drive_mixer_core.sv
// Mecanum drive mixer: three radio pulses in, four motor pulses out.
// The result strobe follows the accepting edge through the valid registers vld_s1 to vld_s6 and result_valid_q.
// Throughput: one item per clock; busy never rises. The depth comes from the
// per-motor scaling multiply and the divide by 1800, a reciprocal multiply over two stages.
// Reset clears the pipeline valid bits and sets every motor's ends back to 1000 and 2000.
// Results are strobed for one cycle; the receiver cannot stall.
module mecanum_drive_mixer_core import mdm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [PULSE_W-1:0]   forward_pulse,
	input  logic [PULSE_W-1:0]   strafe_pulse,
	input  logic [PULSE_W-1:0]   turn_pulse,
	input  logic                 drive_enabled,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PULSE_W-1:0]   cfg_data,
	output logic                 result_valid,
	output logic [PULSE_W-1:0]   front_left_out,
	output logic [PULSE_W-1:0]   front_right_out,
	output logic [PULSE_W-1:0]   rear_right_out,
	output logic [PULSE_W-1:0]   rear_left_out
);

	logic accept;

	pulse_t ends_q [N_REGS];
	pulse_t lo_c [N_MOTORS];
	pulse_t hi_c [N_MOTORS];
	pulse_t lo_q [N_MOTORS];
	pulse_t span_q [N_MOTORS];
	pulse_t neutral_q [N_MOTORS];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, result_valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	pulse_t fwd_s1, str_s1, trn_s1;
	cmd_t   f_s2, s_s2, t_s2;
	cmd_t   mix_c [N_MOTORS];

	logic [U_W-1:0]    u_s3 [N_MOTORS];
	logic [PROD_W-1:0] prod_s4 [N_MOTORS];
	logic [PART_W-1:0] pa_s5 [N_MOTORS];
	logic [PART_W-1:0] pb_s5 [N_MOTORS];
	logic [QSUM_W-1:0] qsum_c [N_MOTORS];
	pulse_t            q_s6 [N_MOTORS];
	pulse_t            out_q [N_MOTORS];

	// The block takes an item every cycle and every register write at once.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ends_q[REG_FL_A] <= pulse_t'(END_A_RESET);
			ends_q[REG_FL_B] <= pulse_t'(END_B_RESET);
			ends_q[REG_FR_A] <= pulse_t'(END_A_RESET);
			ends_q[REG_FR_B] <= pulse_t'(END_B_RESET);
			ends_q[REG_RR_A] <= pulse_t'(END_A_RESET);
			ends_q[REG_RR_B] <= pulse_t'(END_B_RESET);
			ends_q[REG_RL_A] <= pulse_t'(END_A_RESET);
			ends_q[REG_RL_B] <= pulse_t'(END_B_RESET);
		end else if (cfg_valid && cfg_ready) begin
			ends_q[cfg_index] <= cfg_data;
		end
	end

	// Each motor's bounds are the lesser and greater of its two ends.
	always_comb begin
		for (int m = 0; m < N_MOTORS; m++) begin
			if (ends_q[CFG_IDX_W'(2 * m)] < ends_q[CFG_IDX_W'(2 * m + 1)]) begin
				lo_c[m] = ends_q[CFG_IDX_W'(2 * m)];
				hi_c[m] = ends_q[CFG_IDX_W'(2 * m + 1)];
			end else begin
				lo_c[m] = ends_q[CFG_IDX_W'(2 * m + 1)];
				hi_c[m] = ends_q[CFG_IDX_W'(2 * m)];
			end
		end
	end

	// Derived bounds are refreshed every cycle; an item accepted with or after a write reaches them well after it.
	always_ff @(posedge clk) begin
		for (int m = 0; m < N_MOTORS; m++) begin
			lo_q[m]   <= lo_c[m];
			span_q[m] <= hi_c[m] - lo_c[m];
			if (pulse_t'(NEUTRAL) < lo_c[m]) begin
				neutral_q[m] <= lo_c[m];
			end else if (pulse_t'(NEUTRAL) > hi_c[m]) begin
				neutral_q[m] <= hi_c[m];
			end else begin
				neutral_q[m] <= pulse_t'(NEUTRAL);
			end
		end
	end

	// Pipeline valid bits and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			vld_s3         <= 1'b0;
			vld_s4         <= 1'b0;
			vld_s5         <= 1'b0;
			vld_s6         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			vld_s1         <= accept;
			vld_s2         <= vld_s1;
			vld_s3         <= vld_s2;
			vld_s4         <= vld_s3;
			vld_s5         <= vld_s4;
			vld_s6         <= vld_s5;
			result_valid_q <= vld_s6;
		end
	end

	// Four wheel commands, saturating after each add or subtract.
	always_comb begin
		mix_c[MOTOR_FL] = sat_cmd(sum_t'(sat_cmd(sum_t'(f_s2) + sum_t'(s_s2))) + sum_t'(t_s2));
		mix_c[MOTOR_FR] = sat_cmd(sum_t'(sat_cmd(sum_t'(f_s2) - sum_t'(s_s2))) - sum_t'(t_s2));
		mix_c[MOTOR_RR] = sat_cmd(sum_t'(sat_cmd(sum_t'(f_s2) + sum_t'(s_s2))) - sum_t'(t_s2));
		mix_c[MOTOR_RL] = sat_cmd(sum_t'(sat_cmd(sum_t'(f_s2) - sum_t'(s_s2))) + sum_t'(t_s2));
	end

	// The reciprocal product for the divide by 225, put back together.
	always_comb begin
		for (int m = 0; m < N_MOTORS; m++) begin
			qsum_c[m] = {pa_s5[m], QH_W'(0)} + QSUM_W'(pb_s5[m]);
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		// Stage 1: capture the item.
		if (accept) begin
			fwd_s1 <= forward_pulse;
			str_s1 <= strafe_pulse;
			trn_s1 <= turn_pulse;
			en_s1  <= drive_enabled;
		end

		// Stage 2: pulses mapped onto commands.
		f_s2  <= pulse_to_cmd(fwd_s1);
		s_s2  <= pulse_to_cmd(str_s1);
		t_s2  <= pulse_to_cmd(trn_s1);
		en_s2 <= en_s1;

		// Stage 3: mixed commands shifted to start at zero.
		for (int m = 0; m < N_MOTORS; m++) begin
			u_s3[m] <= U_W'(sum_t'(mix_c[m]) + sum_t'(CMD_MAX));
		end
		en_s3 <= en_s2;

		// Stage 4: scale by the motor's span.
		for (int m = 0; m < N_MOTORS; m++) begin
			prod_s4[m] <= PROD_W'(u_s3[m]) * PROD_W'(span_q[m]);
		end
		en_s4 <= en_s3;

		// Stage 5: two partial products of (p >> 3) times the reciprocal of 225.
		for (int m = 0; m < N_MOTORS; m++) begin
			pa_s5[m] <= PART_W'(prod_s4[m][PROD_W-1:PRE_SH+QH_W]) * PART_W'(RECIP225);
			pb_s5[m] <= PART_W'(prod_s4[m][PRE_SH+QH_W-1:PRE_SH]) * PART_W'(RECIP225);
		end
		en_s5 <= en_s4;

		// Stage 6: the quotient, never more than the span.
		for (int m = 0; m < N_MOTORS; m++) begin
			q_s6[m] <= qsum_c[m][RECIP225_SH+PULSE_W-1:RECIP225_SH];
		end
		en_s6 <= en_s5;

		// Result register: offset by the low bound, or the neutral pulse.
		for (int m = 0; m < N_MOTORS; m++) begin
			if (en_s6) begin
				out_q[m] <= q_s6[m] + lo_q[m];
			end else begin
				out_q[m] <= neutral_q[m];
			end
		end
	end

	assign result_valid    = result_valid_q;
	assign front_left_out  = out_q[MOTOR_FL];
	assign front_right_out = out_q[MOTOR_FR];
	assign rear_right_out  = out_q[MOTOR_RR];
	assign rear_left_out   = out_q[MOTOR_RL];

endmodule

>>> rtl/core/mdm_checker.sv
`include "mecanum_drive_mixer_core_macros.svh"

module mdm_checker import mdm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cfg_ready,
	input logic result_valid
);

	// The mixer never refuses an item or a register write.
	`MDM_ASSERT_ALWAYS(a_never_busy, !busy, "busy rose although the mixer takes an item every cycle")
	`MDM_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "register write port refused a write")

	// Every accepted item yields its result after the fixed latency.
	`MDM_ASSERT(a_result_follows, (start && !busy) |-> ##(RESULT_LATENCY) result_valid, "accepted item gave no result")

	// No result appears without an item accepted the same latency earlier.
	`MDM_ASSERT(a_result_sourced, result_valid |-> $past(start && !busy, RESULT_LATENCY), "result strobe without an accepted item")

endmodule

bind mecanum_drive_mixer_core mdm_checker u_mdm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.cfg_ready    (cfg_ready),
	.result_valid (result_valid)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mdm_pkg::*;

	// Cycles without any handshake before the run is abandoned.
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 140;
	localparam int N_PHASES      = 6;

	// The four motor pulses of one result item.
	typedef struct packed {
		pulse_t fl;
		pulse_t fr;
		pulse_t rr;
		pulse_t rl;
	} wheel_pulses_t;

	// One row of directed stimulus; the expected pulses count only when known is set.
	typedef struct {
		pulse_t fwd;
		pulse_t str;
		pulse_t trn;
		logic   en;
		bit     known;
		pulse_t w_fl;
		pulse_t w_fr;
		pulse_t w_rr;
		pulse_t w_rl;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [PULSE_W-1:0]   forward_pulse;
	logic [PULSE_W-1:0]   strafe_pulse;
	logic [PULSE_W-1:0]   turn_pulse;
	logic                 drive_enabled;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PULSE_W-1:0]   cfg_data;
	logic                 result_valid;
	logic [PULSE_W-1:0]   front_left_out;
	logic [PULSE_W-1:0]   front_right_out;
	logic [PULSE_W-1:0]   rear_right_out;
	logic [PULSE_W-1:0]   rear_left_out;

	// Local copy of the motor ends, and the motor pulses still owed by the block.
	pulse_t        motor_ends [N_REGS];
	wheel_pulses_t pending_pulses [$];
	int            fault_count = 0;
	int            quiet_cycles = 0;
	int            idle_pct;

	// Directed rows: neutral, the corners of the pulse range and the map boundaries.
	stim_row_t directed_rows [17] = '{
		'{12'd1100, 12'd1100, 12'd1100, 1'b0, 1'b1, 12'd1500, 12'd1500, 12'd1500, 12'd1500},
		'{12'd4095, 12'd0,    12'd4095, 1'b0, 1'b1, 12'd1500, 12'd1500, 12'd1500, 12'd1500},
		'{12'd1600, 12'd1600, 12'd1600, 1'b1, 1'b1, 12'd2000, 12'd1000, 12'd1500, 12'd2000},
		'{12'd600,  12'd600,  12'd600,  1'b1, 1'b1, 12'd1000, 12'd2000, 12'd1500, 12'd1000},
		'{12'd1100, 12'd1100, 12'd1100, 1'b1, 1'b1, 12'd1500, 12'd1500, 12'd1500, 12'd1500},
		'{12'd0,    12'd0,    12'd0,    1'b1, 1'b1, 12'd1000, 12'd2000, 12'd1500, 12'd1000},
		'{12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1, 12'd2000, 12'd1000, 12'd1500, 12'd2000},
		'{12'd1600, 12'd600,  12'd1100, 1'b1, 1'b0, '0, '0, '0, '0},
		'{12'd1100, 12'd1600, 12'd1100, 1'b1, 1'b0, '0, '0, '0, '0},
		'{12'd1100, 12'd1100, 12'd1600, 1'b1, 1'b0, '0, '0, '0, '0},
		'{12'd599,  12'd1599, 12'd601,  1'b1, 1'b0, '0, '0, '0, '0},
		'{12'd1601, 12'd600,  12'd1099, 1'b1, 1'b0, '0, '0, '0, '0},
		'{12'd2048, 12'd2047, 12'd1101, 1'b1, 1'b0, '0, '0, '0, '0},
		'{12'hAAA,  12'h555,  12'hFFF,  1'b1, 1'b0, '0, '0, '0, '0},
		'{12'h555,  12'hAAA,  12'h000,  1'b1, 1'b0, '0, '0, '0, '0},
		'{12'd1350, 12'd850,  12'd1234, 1'b1, 1'b0, '0, '0, '0, '0},
		'{12'd1101, 12'd1099, 12'd1102, 1'b1, 1'b0, '0, '0, '0, '0}
	};

	mecanum_drive_mixer_core dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Saturate a wheel command to the command range.
	function automatic int clip_cmd(input int v);
		if (v > CMD_MAX) begin
			return CMD_MAX;
		end
		if (v < -CMD_MAX) begin
			return -CMD_MAX;
		end
		return v;
	endfunction

	// Radio pulse to command: linear map truncating toward zero, then saturate.
	function automatic int radio_to_cmd(input pulse_t p);
		int offset;
		offset = int'(p) - IN_LO;
		return clip_cmd(offset * (2 * CMD_MAX) / (IN_HI - IN_LO) - CMD_MAX);
	endfunction

	// Wheel command to motor pulse within the motor's bounds.
	function automatic pulse_t wheel_to_pulse(input int cmd, input int motor, input logic en);
		int a;
		int b;
		int lo;
		int hi;
		int v;
		a  = int'(motor_ends[2 * motor]);
		b  = int'(motor_ends[2 * motor + 1]);
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		v  = en ? (cmd + CMD_MAX) * (hi - lo) / (2 * CMD_MAX) + lo : NEUTRAL;
		if (v < lo) begin
			v = lo;
		end else if (v > hi) begin
			v = hi;
		end
		return pulse_t'(v);
	endfunction

	// Mecanum mixing of forward, strafe and turn into the four motor pulses.
	function automatic wheel_pulses_t mix_wheels(input pulse_t fp, input pulse_t sp,
			input pulse_t tp, input logic en);
		int            f;
		int            s;
		int            t;
		wheel_pulses_t w;
		f    = radio_to_cmd(fp);
		s    = radio_to_cmd(sp);
		t    = radio_to_cmd(tp);
		w.fl = wheel_to_pulse(clip_cmd(clip_cmd(f + s) + t), MOTOR_FL, en);
		w.fr = wheel_to_pulse(clip_cmd(clip_cmd(f - s) - t), MOTOR_FR, en);
		w.rr = wheel_to_pulse(clip_cmd(clip_cmd(f + s) - t), MOTOR_RR, en);
		w.rl = wheel_to_pulse(clip_cmd(clip_cmd(f - s) + t), MOTOR_RL, en);
		return w;
	endfunction

	// Mostly pulses near the working range, some at its ends, some anywhere.
	function automatic pulse_t random_pulse();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			return pulse_t'($urandom_range(IN_LO - 150, IN_HI + 150));
		end
		if (pick < 85) begin
			return pulse_t'(($urandom_range(0, 1) ? IN_HI : IN_LO) + $urandom_range(0, 6) - 3);
		end
		return pulse_t'($urandom_range(0, 4095));
	endfunction

	task automatic report_fault(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		fault_count++;
	endtask

	task automatic check_field(input string fname, input pulse_t got, input pulse_t want);
		if (got !== want) begin
			report_fault($sformatf("%s is %0d, expected %0d", fname, got, want));
		end
	endtask

	// Present one item after a random gap and record its expected pulses on acceptance.
	task automatic issue_item(input pulse_t fp, input pulse_t sp, input pulse_t tp,
			input logic en, input bit known, input wheel_pulses_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start         <= 1'b1;
		forward_pulse <= fp;
		strafe_pulse  <= sp;
		turn_pulse    <= tp;
		drive_enabled <= en;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		pending_pulses.push_back(known ? want : mix_wheels(fp, sp, tp, en));
	endtask

	// Write all eight motor ends, in register order, while the block is idle.
	task automatic load_ends(input pulse_t vals [N_REGS]);
		for (int i = 0; i < N_REGS; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) begin
				@(posedge clk);
			end
			motor_ends[i] = vals[i];
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result checker: every strobed item is matched against the oldest expectation.
	always @(posedge clk) begin
		wheel_pulses_t want;
		if (arst_n === 1'b1 && result_valid === 1'b1) begin
			if (pending_pulses.size() == 0) begin
				report_fault("result item with no item outstanding");
			end else begin
				want = pending_pulses.pop_front();
				check_field("front_left_out", front_left_out, want.fl);
				check_field("front_right_out", front_right_out, want.fr);
				check_field("rear_right_out", rear_right_out, want.rr);
				check_field("rear_left_out", rear_left_out, want.rl);
			end
		end
	end

	// Watchdog: any handshake counts as progress.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("ERROR at %0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("mecanum_drive_mixer_core verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus: directed rows under the reset ends, then random items across
	// several end settings and idle rates.
	initial begin
		pulse_t        rnd_ends [N_REGS];
		wheel_pulses_t want;
		stim_row_t     row;
		arst_n        = 1'b0;
		start         = 1'b0;
		forward_pulse = '0;
		strafe_pulse  = '0;
		turn_pulse    = '0;
		drive_enabled = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_FL_A;
		cfg_data      = '0;
		for (int m = 0; m < N_MOTORS; m++) begin
			motor_ends[2 * m]     = pulse_t'(END_A_RESET);
			motor_ends[2 * m + 1] = pulse_t'(END_B_RESET);
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			idle_pct = (ph < 2) ? 30 : (ph < 4) ? 86 : 0;
			if (ph == 1) begin
				// Full span, swapped ends and equal ends.
				load_ends('{12'd0, 12'd4095, 12'd4095, 12'd0,
					12'd1500, 12'd1500, 12'd1000, 12'd2000});
			end else if (ph == 2) begin
				load_ends('{12'd0, 12'd0, 12'd4095, 12'd4095,
					12'd2000, 12'd1000, 12'd1234, 12'd1789});
			end else if (ph > 2) begin
				for (int i = 0; i < N_REGS; i += 2) begin
					rnd_ends[i]     = pulse_t'($urandom_range(0, 4095));
					rnd_ends[i + 1] = ($urandom_range(0, 4) == 0) ? rnd_ends[i]
						: pulse_t'($urandom_range(0, 4095));
				end
				load_ends(rnd_ends);
			end

			if (ph == 0) begin
				foreach (directed_rows[r]) begin
					row  = directed_rows[r];
					want = '{row.w_fl, row.w_fr, row.w_rr, row.w_rl};
					issue_item(row.fwd, row.str, row.trn, row.en, row.known, want);
				end
			end

			repeat (RANDOM_ITEMS) begin
				issue_item(random_pulse(), random_pulse(), random_pulse(),
					($urandom_range(0, 99) < 88), 1'b0, '0);
			end
			@(negedge clk);
			start <= 1'b0;

			// Every item yields a result, so the block is idle once all have come.
			while (pending_pulses.size() != 0) begin
				@(posedge clk);
			end
		end

		repeat (RESULT_LATENCY + 4) @(posedge clk);
		if (fault_count == 0) begin
			$display("mecanum_drive_mixer_core verification clean");
		end else begin
			$display("mecanum_drive_mixer_core verification failed");
		end
		$finish;
	end

endmodule
